>>> rtl/core/mexp_pkg.sv
// shared types and constants for the modular exponentiation unit
`default_nettype none

package mexp_pkg;

  // default sizes and register reset
  localparam int          EXP_WIDTH_DEF = 32;
  localparam int          MOD_WIDTH_DEF = 32;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int RESULT_W = 64;
  localparam int OPCODE_W = 2;
  localparam int CNT_W    = 6;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_POW_WRAP = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POW_MOD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_INVERSE  = 2'd2;

  // register index of the modulus
  localparam logic REG_MODULUS = 1'b0;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_MUL,
    ST_RED,
    ST_FINISH
  } mexp_state_t;

  // where a finished product is written back
  typedef enum logic [1:0] {
    TGT_ACC,
    TGT_BASE,
    TGT_INIT
  } mexp_tgt_t;

endpackage

`default_nettype wire

>>> rtl/core/modular_exponentiation_unit.sv
// modular exponentiation unit: right-to-left square and multiply on one shared multiplier
// sequence: per exponent bit up to two products, each after a bit decision state; a modular
//   product is a multiply step then MOD_WIDTH reduction steps (one quotient bit each), a
//   wrapping product sums low-by-low, low-by-high and high-by-low partial products; modular
//   items start with a reduction of the full 32-bit base
// throughput: one item at a time, the next is accepted once the result is loaded; a result
//   waits in an output register; reset is synchronous active-low, clears the sequencer and
//   output valid, and returns the modulus to 1000000007
`default_nettype none

module modular_exponentiation_unit #(
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input item channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [mexp_pkg::OPCODE_W-1:0]       in_opcode,
  input  wire logic [mexp_pkg::DATA_W-1:0]         in_base_value,
  input  wire logic [mexp_pkg::DATA_W-1:0]         in_exponent,
  // result item channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [mexp_pkg::RESULT_W-1:0]            out_result,
  // configuration port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [2:0]                          cfg_paddr,
  input  wire logic [mexp_pkg::DATA_W-1:0]         cfg_pwdata,
  output logic [mexp_pkg::DATA_W-1:0]              cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int EXP_BITS  = (EXP_WIDTH < mexp_pkg::DATA_W) ? EXP_WIDTH : mexp_pkg::DATA_W;
  localparam int RED_SHIFT = mexp_pkg::RESULT_W - MOD_WIDTH;
  localparam int RW        = mexp_pkg::RESULT_W;
  localparam int DW        = mexp_pkg::DATA_W;
  localparam int CW        = mexp_pkg::CNT_W;

  mexp_pkg::mexp_state_t state_r, state_nxt;
  mexp_pkg::mexp_tgt_t   tgt_r, tgt_nxt;

  logic                 wrap_r, wrap_nxt;
  logic                 sq_phase_r, sq_phase_nxt;
  logic [1:0]           mph_r, mph_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [EXP_BITS-1:0]  exp_r, exp_nxt;
  logic [RW-1:0]        acc_r, acc_nxt;
  logic [RW-1:0]        base_r, base_nxt;
  logic [RW-1:0]        work_r, work_nxt;
  logic [MOD_WIDTH-1:0] rem_r, rem_nxt;
  logic [DW-1:0]        mod_r;
  logic                 out_valid_r;
  logic [RW-1:0]        out_result_r;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 cfg_write;
  logic [MOD_WIDTH-1:0] mod_w;
  logic                 mod_zero;
  logic                 mod_one;
  logic                 in_is_wrap;
  logic                 in_is_mod;
  logic [DW-1:0]        inv_full;
  logic [EXP_BITS-1:0]  exp_in;
  logic [EXP_BITS-1:0]  exp_inv;
  logic [RW-1:0]        opnd_x;
  logic [DW-1:0]        mul_a;
  logic [DW-1:0]        mul_b;
  logic [RW-1:0]        mul_p;
  logic [DW-1:0]        wrap_hi;
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   trial_diff;
  logic [MOD_WIDTH-1:0] rem_step;
  logic                 commit_en;
  logic [RW-1:0]        commit_val;

  // configuration register
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == mexp_pkg::REG_MODULUS) ? mod_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_write && (cfg_paddr[2] == mexp_pkg::REG_MODULUS)) begin
      mod_r <= cfg_pwdata;
    end
  end

  // modulus and item decode
  assign mod_w      = mod_r[MOD_WIDTH-1:0];
  assign mod_zero   = (mod_w == '0);
  assign mod_one    = (mod_w == MOD_WIDTH'(1));
  assign in_accept  = in_valid && !in_stall;
  assign in_is_wrap = (in_opcode == mexp_pkg::OP_POW_WRAP);
  assign in_is_mod  = ((in_opcode == mexp_pkg::OP_POW_MOD) ||
                       (in_opcode == mexp_pkg::OP_INVERSE)) && !mod_zero;
  assign inv_full   = (mod_w >= MOD_WIDTH'(2)) ? (DW'(mod_w) - DW'(2)) : '0;
  assign exp_in     = in_exponent[EXP_BITS-1:0];
  assign exp_inv    = inv_full[EXP_BITS-1:0];
  assign out_free   = !out_valid_r || !out_stall;

  // shared multiplier, operands picked by partial-product phase
  assign opnd_x = (tgt_r == mexp_pkg::TGT_ACC) ? acc_r : base_r;

  always_comb begin
    case (mph_r)
      2'd0: begin
        mul_a = opnd_x[DW-1:0];
        mul_b = base_r[DW-1:0];
      end
      2'd1: begin
        mul_a = opnd_x[DW-1:0];
        mul_b = base_r[RW-1:DW];
      end
      default: begin
        mul_a = opnd_x[RW-1:DW];
        mul_b = base_r[DW-1:0];
      end
    endcase
  end

  assign mul_p   = RW'(mul_a) * RW'(mul_b);
  assign wrap_hi = work_r[RW-1:DW] + mul_p[DW-1:0];

  // one restoring reduction step
  assign trial      = {rem_r, work_r[RW-1]};
  assign trial_diff = trial - {1'b0, mod_w};
  assign rem_step   = (trial >= {1'b0, mod_w}) ? trial_diff[MOD_WIDTH-1:0]
                                               : trial[MOD_WIDTH-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_is_wrap) begin
            state_nxt = mexp_pkg::ST_BIT;
          end else if (in_is_mod) begin
            state_nxt = mexp_pkg::ST_RED;
          end else begin
            state_nxt = mexp_pkg::ST_FINISH;
          end
        end
      end
      mexp_pkg::ST_BIT: begin
        state_nxt = (exp_r == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_MUL;
      end
      mexp_pkg::ST_MUL: begin
        if (!wrap_r) begin
          state_nxt = mexp_pkg::ST_RED;
        end else if (mph_r == 2'd2) begin
          state_nxt = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_RED: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = (state_r != mexp_pkg::ST_IDLE);
    out_load = (state_r == mexp_pkg::ST_FINISH) && out_free;
  end

  // datapath next values
  always_comb begin
    tgt_nxt      = tgt_r;
    wrap_nxt     = wrap_r;
    sq_phase_nxt = sq_phase_r;
    mph_nxt      = mph_r;
    cnt_nxt      = cnt_r;
    exp_nxt      = exp_r;
    acc_nxt      = acc_r;
    base_nxt     = base_r;
    work_nxt     = work_r;
    rem_nxt      = rem_r;
    commit_en    = 1'b0;
    commit_val   = work_r;

    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_accept) begin
          wrap_nxt     = in_is_wrap;
          sq_phase_nxt = 1'b0;
          mph_nxt      = 2'd0;
          unique case (in_opcode) inside
            mexp_pkg::OP_POW_WRAP: begin
              acc_nxt  = RW'(1);
              base_nxt = RW'(in_base_value);
              exp_nxt  = exp_in;
            end
            mexp_pkg::OP_POW_MOD, mexp_pkg::OP_INVERSE: begin
              // reduce the base first, all 32 bits shifted through
              acc_nxt  = mod_one ? '0 : RW'(1);
              exp_nxt  = (in_opcode == mexp_pkg::OP_POW_MOD) ? exp_in : exp_inv;
              work_nxt = {in_base_value, {(RW-DW){1'b0}}};
              rem_nxt  = '0;
              cnt_nxt  = CW'(DW);
              tgt_nxt  = mexp_pkg::TGT_INIT;
              if (mod_zero) begin
                acc_nxt = '0;
              end
            end
            default: begin
              acc_nxt = '0;
            end
          endcase
        end
      end
      mexp_pkg::ST_BIT: begin
        mph_nxt = 2'd0;
        tgt_nxt = (!sq_phase_r && exp_r[0]) ? mexp_pkg::TGT_ACC : mexp_pkg::TGT_BASE;
      end
      mexp_pkg::ST_MUL: begin
        if (!wrap_r) begin
          // product high half is already below the modulus
          rem_nxt  = mul_p[MOD_WIDTH +: MOD_WIDTH];
          work_nxt = mul_p << RED_SHIFT;
          cnt_nxt  = CW'(MOD_WIDTH);
        end else begin
          case (mph_r)
            2'd0: begin
              work_nxt = mul_p;
              mph_nxt  = 2'd1;
            end
            2'd1: begin
              work_nxt = {wrap_hi, work_r[DW-1:0]};
              mph_nxt  = 2'd2;
            end
            default: begin
              commit_en  = 1'b1;
              commit_val = {wrap_hi, work_r[DW-1:0]};
              mph_nxt    = 2'd0;
            end
          endcase
        end
      end
      mexp_pkg::ST_RED: begin
        rem_nxt  = rem_step;
        work_nxt = work_r << 1;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          commit_en  = 1'b1;
          commit_val = RW'(rem_step);
        end
      end
      default: begin
      end
    endcase

    // write back a finished product
    if (commit_en) begin
      case (tgt_r)
        mexp_pkg::TGT_ACC: begin
          acc_nxt      = commit_val;
          sq_phase_nxt = 1'b1;
        end
        mexp_pkg::TGT_BASE: begin
          base_nxt     = commit_val;
          sq_phase_nxt = 1'b0;
          exp_nxt      = exp_r >> 1;
        end
        default: begin
          base_nxt = commit_val;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    wrap_r     <= wrap_nxt;
    sq_phase_r <= sq_phase_nxt;
    mph_r      <= mph_nxt;
    cnt_r      <= cnt_nxt;
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    if (out_load) begin
      out_result_r <= acc_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // partial remainder stays below the modulus while reducing
  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_RED) |-> (rem_r < mod_w))
    else $error("partial remainder not below modulus");

  // modular operands stay reduced between products
  a_opnd_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == mexp_pkg::ST_BIT) && !wrap_r) |->
      ((acc_r < RW'(mod_w)) && (base_r < RW'(mod_w))))
    else $error("modular operand not reduced");

  // a new result only appears after the finish state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mexp_pkg::ST_FINISH))
    else $error("result shown without finishing");

endmodule

`default_nettype wire
